// File: sv/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Used by ffba_ctrl, ffba_dp and first_fit_block_allocator; depends on nothing.
`default_nettype none

package ffba_pkg;

  localparam int OP_W           = 2;
  localparam int REQ_W          = 20;
  localparam int ADDR_W         = 20;
  localparam int ST_W           = 2;
  localparam int INIT_SIZE_W    = 17;
  localparam int HEAP_LIMIT_W   = 21;
  localparam int CFG_DATA_W     = 21;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [INIT_SIZE_W-1:0]  INIT_SIZE_RESET  = 17'd4096;
  localparam logic [HEAP_LIMIT_W-1:0] HEAP_LIMIT_RESET = 21'd1048576;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_LIMIT   = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_LSCAN_INIT,
    DP_LSCAN,
    DP_ALLOC_START,
    DP_FSCAN,
    DP_TAKE,
    DP_SHIFT,
    DP_EXTEND,
    DP_PUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LSCAN,
    S_LHIT,
    S_ALLOC,
    S_FSCAN,
    S_TAKE,
    S_SHIFT,
    S_EXTEND,
    S_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_res;
    logic    res_keep;
    status_t res_st;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    addr_zero;
    logic    live_found;
    logic    live_end;
    logic    grow;
    logic    free_full;
    logic    slot_done;
    logic    live_full;
    logic    free_found;
    logic    free_end;
    logic    split;
    logic    shift_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/ffba_dp.sv
// Datapath of the allocator: free list and live table memories, scan pointers,
// heap top, configuration and result registers. Driven by ffba_ctrl; uses ffba_pkg.
`default_nettype none

module ffba_dp #(
  parameter int FREE_ENTRIES = 64,
  parameter int LIVE_ENTRIES = 64,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [ffba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [ffba_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [ffba_pkg::OP_W-1:0]            opcode,
  input  wire logic [ffba_pkg::REQ_W-1:0]           request_size,
  input  wire logic [ffba_pkg::ADDR_W-1:0]          block_address,
  input  wire ffba_pkg::dp_cmd_t                    cmd,
  output ffba_pkg::dp_status_t                      st,
  output logic [ffba_pkg::ADDR_W-1:0]               result_address,
  output logic [ffba_pkg::ST_W-1:0]                 status
);

  localparam int DW  = ((ffba_pkg::ADDR_W > ffba_pkg::HEAP_LIMIT_W) ?
                        ffba_pkg::ADDR_W : ffba_pkg::HEAP_LIMIT_W) + 2;
  localparam int FIW = $clog2(FREE_ENTRIES);
  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int LIW = $clog2(LIVE_ENTRIES);
  localparam int LCW = $clog2(LIVE_ENTRIES + 1);
  localparam logic [DW-1:0]  HDR       = DW'(HEADER_BYTES);
  localparam logic [DW-1:0]  ADDR_MASK = {DW{1'b1}} >> (DW - ffba_pkg::ADDR_W);
  localparam logic [FCW-1:0] F_MAX     = FCW'(FREE_ENTRIES);
  localparam logic [LCW-1:0] L_MAX     = LCW'(LIVE_ENTRIES);

  // configuration
  logic [ffba_pkg::INIT_SIZE_W-1:0]  initial_size;
  logic [ffba_pkg::HEAP_LIMIT_W-1:0] heap_limit;

  // latched request
  ffba_pkg::opcode_t          op_r;
  logic [ffba_pkg::REQ_W-1:0] size_r;
  logic [ffba_pkg::ADDR_W-1:0] addr_r;

  // free list, stored in reverse: the list front is entry free_count-1
  logic [DW-1:0] fs_mem [FREE_ENTRIES];
  logic [DW-1:0] fl_mem [FREE_ENTRIES];
  logic [DW-1:0] fs_rdata, fl_rdata;
  logic [FIW-1:0] f_raddr, f_waddr;
  logic           f_we;
  logic [DW-1:0]  f_wstart, f_wlen;
  logic [FCW-1:0] free_count;

  // live table
  logic [DW-1:0] ls_mem [LIVE_ENTRIES];
  logic [DW-1:0] ll_mem [LIVE_ENTRIES];
  logic [DW-1:0] ls_rdata, ll_rdata;
  logic [LIVE_ENTRIES-1:0] live_valid;
  logic           l_we;
  logic [DW-1:0]  l_wstart, l_wlen;

  logic [DW-1:0] heap_top;
  logic          heap_started;

  // free scan / shift pointers
  logic [FCW-1:0] fptr;
  logic           fpv;
  logic [FIW-1:0] fpidx;
  logic           ffound;
  logic [FIW-1:0] fidx;
  logic [DW-1:0]  fstart, flen;

  // live scan
  logic [LCW-1:0] lptr;
  logic           lpv;
  logic [LIW-1:0] lpidx;
  logic           lfound;
  logic [LIW-1:0] kidx;
  logic [DW-1:0]  kstart, klen;

  // slot search
  logic [LCW-1:0] sptr;
  logic           slot_done;
  logic [LIW-1:0] slot;

  logic [ffba_pkg::ADDR_W-1:0] res_addr;
  ffba_pkg::status_t           res_st;

  logic [DW-1:0]  size_ext, addr_ext, lim, need, grant_start, grant_len, setup_len;
  logic [FCW-1:0] fptr_dec;
  logic           split, oom, live_hit, free_hit, grant;

  always_comb begin
    size_ext    = DW'(size_r);
    addr_ext    = DW'(addr_r);
    lim         = (DW'(heap_limit) < ADDR_MASK) ? DW'(heap_limit) : ADDR_MASK;
    need        = heap_top + size_ext + HDR;
    oom         = need > lim;
    split       = flen > (size_ext + HDR);
    setup_len   = (DW'(initial_size) > HDR) ? (DW'(initial_size) - HDR) : '0;
    fptr_dec    = fptr - 1'b1;
    slot        = sptr[LIW-1:0];
    slot_done   = (sptr == L_MAX) || !live_valid[slot];
    live_hit    = lpv && live_valid[lpidx] && ((ls_rdata + HDR) == addr_ext);
    free_hit    = fpv && (fl_rdata >= size_ext);
    grant_start = (cmd.op == ffba_pkg::DP_TAKE) ? fstart : heap_top;
    grant_len   = (cmd.op == ffba_pkg::DP_TAKE) ? (split ? size_ext : flen) : size_ext;
    grant       = (cmd.op == ffba_pkg::DP_TAKE) || (cmd.op == ffba_pkg::DP_EXTEND && !oom);
  end

  always_comb begin
    st.opcode     = op_r;
    st.addr_zero  = (addr_r == '0);
    st.live_found = lfound;
    st.live_end   = !lfound && !lpv && (lptr == L_MAX);
    st.grow       = size_ext > klen;
    st.free_full  = (free_count == F_MAX);
    st.slot_done  = slot_done;
    st.live_full  = (sptr == L_MAX);
    st.free_found = ffound;
    st.free_end   = !ffound && !fpv && (fptr == '0);
    st.split      = split;
    st.shift_done = !fpv && (fptr > free_count);
  end

  // free list memory ports
  always_comb begin
    f_raddr  = (cmd.op == ffba_pkg::DP_SHIFT) ? fptr[FIW-1:0] : fptr_dec[FIW-1:0];
    f_we     = 1'b0;
    f_waddr  = fidx;
    f_wstart = fstart + HDR + size_ext;
    f_wlen   = flen - size_ext - HDR;
    case (cmd.op)
      ffba_pkg::DP_ALLOC_START: begin
        f_we     = !heap_started;
        f_waddr  = '0;
        f_wstart = '0;
        f_wlen   = setup_len;
      end
      ffba_pkg::DP_TAKE: begin
        f_we = split;
      end
      ffba_pkg::DP_SHIFT: begin
        f_we     = fpv;
        f_waddr  = fpidx;
        f_wstart = fs_rdata;
        f_wlen   = fl_rdata;
      end
      ffba_pkg::DP_PUSH: begin
        f_we     = 1'b1;
        f_waddr  = free_count[FIW-1:0];
        f_wstart = kstart;
        f_wlen   = klen;
      end
      default: begin
        f_we = 1'b0;
      end
    endcase
    l_we     = grant;
    l_wstart = grant_start;
    l_wlen   = grant_len;
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fs_mem[f_waddr] <= f_wstart;
      fl_mem[f_waddr] <= f_wlen;
    end
    fs_rdata <= fs_mem[f_raddr];
    fl_rdata <= fl_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      ls_mem[slot] <= l_wstart;
      ll_mem[slot] <= l_wlen;
    end
    ls_rdata <= ls_mem[lptr[LIW-1:0]];
    ll_rdata <= ll_mem[lptr[LIW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == ffba_pkg::DP_LOAD) begin
      op_r   <= ffba_pkg::opcode_t'(opcode);
      size_r <= request_size;
      addr_r <= block_address;
    end
    if (cmd.op == ffba_pkg::DP_LSCAN && !lfound && live_hit) begin
      kidx   <= lpidx;
      kstart <= ls_rdata;
      klen   <= ll_rdata;
    end
    if (cmd.op == ffba_pkg::DP_FSCAN && !ffound && free_hit) begin
      fidx   <= fpidx;
      fstart <= fs_rdata;
      flen   <= fl_rdata;
    end
    if (cmd.set_res) begin
      res_addr <= cmd.res_keep ? addr_r : '0;
      res_st   <= cmd.res_st;
    end
    if (cmd.op == ffba_pkg::DP_TAKE || cmd.op == ffba_pkg::DP_EXTEND) begin
      res_addr <= grant ? ffba_pkg::ADDR_W'((grant_start + HDR) & ADDR_MASK) : '0;
      res_st   <= grant ? ffba_pkg::ST_OK : ffba_pkg::ST_OOM;
    end
    if (cmd.out_load) begin
      result_address <= res_addr;
      status         <= res_st;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_size <= ffba_pkg::INIT_SIZE_RESET;
      heap_limit   <= ffba_pkg::HEAP_LIMIT_RESET;
      free_count   <= '0;
      live_valid   <= '0;
      heap_top     <= '0;
      heap_started <= 1'b0;
      fptr         <= '0;
      fpv          <= 1'b0;
      fpidx        <= '0;
      ffound       <= 1'b0;
      lptr         <= '0;
      lpv          <= 1'b0;
      lpidx        <= '0;
      lfound       <= 1'b0;
      sptr         <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == ffba_pkg::CFG_INITIAL_SIZE) begin
          initial_size <= cfg_data[ffba_pkg::INIT_SIZE_W-1:0];
        end
        if (cfg_index == ffba_pkg::CFG_HEAP_LIMIT) begin
          heap_limit <= cfg_data[ffba_pkg::HEAP_LIMIT_W-1:0];
        end
      end
      if (grant) begin
        live_valid[slot] <= 1'b1;
      end
      case (cmd.op)
        ffba_pkg::DP_LSCAN_INIT: begin
          lptr   <= '0;
          lpv    <= 1'b0;
          lfound <= 1'b0;
        end
        ffba_pkg::DP_LSCAN: begin
          if (!lfound) begin
            if (live_hit) begin
              lfound <= 1'b1;
              lpv    <= 1'b0;
            end else if (lptr != L_MAX) begin
              lpv   <= 1'b1;
              lpidx <= lptr[LIW-1:0];
              lptr  <= lptr + 1'b1;
            end else begin
              lpv <= 1'b0;
            end
          end
        end
        ffba_pkg::DP_ALLOC_START: begin
          if (!heap_started) begin
            heap_started <= 1'b1;
            heap_top     <= DW'(initial_size);
            free_count   <= FCW'(1);
          end
          fptr   <= heap_started ? free_count : FCW'(1);
          fpv    <= 1'b0;
          ffound <= 1'b0;
          sptr   <= '0;
        end
        ffba_pkg::DP_FSCAN: begin
          if (!slot_done) begin
            sptr <= sptr + 1'b1;
          end
          if (!ffound) begin
            if (free_hit) begin
              ffound <= 1'b1;
              fpv    <= 1'b0;
            end else if (fptr != '0) begin
              fpv   <= 1'b1;
              fpidx <= fptr_dec[FIW-1:0];
              fptr  <= fptr_dec;
            end else begin
              fpv <= 1'b0;
            end
          end
        end
        ffba_pkg::DP_TAKE: begin
          if (!split) begin
            free_count <= free_count - 1'b1;
            fptr       <= FCW'(fidx) + 1'b1;
            fpv        <= 1'b0;
          end
        end
        ffba_pkg::DP_SHIFT: begin
          // move the entries stored above the taken one down by one
          if (fptr <= free_count) begin
            fpv   <= 1'b1;
            fpidx <= fptr_dec[FIW-1:0];
            fptr  <= fptr + 1'b1;
          end else begin
            fpv <= 1'b0;
          end
        end
        ffba_pkg::DP_EXTEND: begin
          if (!oom) begin
            heap_top <= need;
          end
        end
        ffba_pkg::DP_PUSH: begin
          free_count       <= free_count + 1'b1;
          live_valid[kidx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= F_MAX)
    else $error("free list count beyond capacity");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ffba_pkg::DP_PUSH |=> free_count == $past(free_count) + 1'b1)
    else $error("free push did not grow the list");

  a_top_monotonic: assert property (@(posedge clk) disable iff (rst)
    heap_started |=> heap_top >= $past(heap_top))
    else $error("heap top moved down");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ffba_pkg::DP_SHIFT && fpv) |-> FCW'(fpidx) < free_count)
    else $error("shift wrote beyond the free list");
`endif

endmodule

`default_nettype wire

// File: sv/ffba_ctrl.sv
// Controller of the allocator: request sequencing state machine and output valid.
// Issues commands to ffba_dp; uses ffba_pkg.
`default_nettype none

module ffba_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ffba_pkg::dp_status_t st,
  output ffba_pkg::dp_cmd_t         cmd
);

  ffba_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = ffba_pkg::DP_IDLE;
    cmd.set_res  = 1'b0;
    cmd.res_keep = 1'b0;
    cmd.res_st   = ffba_pkg::ST_OK;
    cmd.out_load = 1'b0;
    in_stall     = (state != ffba_pkg::S_IDLE);
    case (state)
      ffba_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ffba_pkg::DP_LOAD;
          state_next = ffba_pkg::S_DECODE;
        end
      end
      ffba_pkg::S_DECODE: begin
        case (st.opcode)
          ffba_pkg::OP_ALLOC: begin
            state_next = ffba_pkg::S_ALLOC;
          end
          ffba_pkg::OP_FREE: begin
            if (st.addr_zero) begin
              cmd.set_res = 1'b1;
              state_next  = ffba_pkg::S_FINISH;
            end else begin
              cmd.op     = ffba_pkg::DP_LSCAN_INIT;
              state_next = ffba_pkg::S_LSCAN;
            end
          end
          ffba_pkg::OP_RESIZE: begin
            if (st.addr_zero) begin
              state_next = ffba_pkg::S_ALLOC;
            end else begin
              cmd.op     = ffba_pkg::DP_LSCAN_INIT;
              state_next = ffba_pkg::S_LSCAN;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_next  = ffba_pkg::S_FINISH;
          end
        endcase
      end
      ffba_pkg::S_LSCAN: begin
        cmd.op = ffba_pkg::DP_LSCAN;
        if (st.live_found) begin
          state_next = ffba_pkg::S_LHIT;
        end else if (st.live_end) begin
          cmd.set_res = 1'b1;
          cmd.res_st  = ffba_pkg::ST_NOT_FOUND;
          state_next  = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_LHIT: begin
        if (st.opcode == ffba_pkg::OP_FREE) begin
          cmd.set_res = 1'b1;
          if (st.free_full) begin
            cmd.res_st = ffba_pkg::ST_FULL;
          end else begin
            cmd.op = ffba_pkg::DP_PUSH;
          end
          state_next = ffba_pkg::S_FINISH;
        end else if (st.grow) begin
          state_next = ffba_pkg::S_ALLOC;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_keep = 1'b1;
          state_next   = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_ALLOC: begin
        cmd.op     = ffba_pkg::DP_ALLOC_START;
        state_next = ffba_pkg::S_FSCAN;
      end
      ffba_pkg::S_FSCAN: begin
        cmd.op = ffba_pkg::DP_FSCAN;
        if (st.slot_done && (st.free_found || st.free_end)) begin
          if (st.live_full) begin
            cmd.set_res = 1'b1;
            cmd.res_st  = ffba_pkg::ST_FULL;
            state_next  = ffba_pkg::S_FINISH;
          end else if (st.free_found) begin
            state_next = ffba_pkg::S_TAKE;
          end else begin
            state_next = ffba_pkg::S_EXTEND;
          end
        end
      end
      ffba_pkg::S_TAKE: begin
        cmd.op     = ffba_pkg::DP_TAKE;
        state_next = st.split ? ffba_pkg::S_FINISH : ffba_pkg::S_SHIFT;
      end
      ffba_pkg::S_SHIFT: begin
        cmd.op = ffba_pkg::DP_SHIFT;
        if (st.shift_done) begin
          state_next = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_EXTEND: begin
        cmd.op     = ffba_pkg::DP_EXTEND;
        state_next = ffba_pkg::S_FINISH;
      end
      ffba_pkg::S_FINISH: begin
        // hold until the output register is free or being drained
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffba_pkg::S_IDLE;
      end
    endcase
    out_valid_next = cmd.out_load || (out_valid && out_stall);
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ffba_pkg::DP_LOAD) |=> state == ffba_pkg::S_DECODE)
    else $error("request load outside idle");
`endif

endmodule

`default_nettype wire

// File: sv/first_fit_block_allocator.sv
// First-fit heap block allocator, top level: joins ffba_ctrl and ffba_dp.
// Uses ffba_pkg.
//
// Input channel: in_valid/in_stall carrying opcode, request_size and
// block_address; one transfer per request. Output channel: out_valid/out_stall
// carrying result_address and status; exactly one result per request.
// Configuration: cfg_write with cfg_index and cfg_data, to be written only
// while idle; the user is bound to this, the block itself does not enforce it.
// One request is in work at a time; after its result is loaded the block
// returns to idle and takes the next transfer there. An unused opcode or a
// free of address 0 goes from decode straight to finish. An allocate walks the
// free list beside the search for a spare live slot. Taking a whole block then
// closes the gap, moving the entries ahead of it in the list down by one.
// Free and resize first search the live table; a growing resize goes on as
// an allocate. Each table memory has a single read port.
// Reset clears the free count, live valid bits and heap top; the first
// allocate after reset sets up the heap from initial_size. A finished result
// waits in the output register while the next request is taken; a request
// that finishes while that register is still stalled holds until it drains.
`default_nettype none

module first_fit_block_allocator #(
  parameter int FREE_ENTRIES = 64,
  parameter int LIVE_ENTRIES = 64,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ffba_pkg::OP_W-1:0]        opcode,
  input  wire logic [ffba_pkg::REQ_W-1:0]       request_size,
  input  wire logic [ffba_pkg::ADDR_W-1:0]      block_address,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ffba_pkg::ADDR_W-1:0]           result_address,
  output logic [ffba_pkg::ST_W-1:0]             status,
  input  wire logic                             cfg_write,
  input  wire logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ffba_pkg::dp_cmd_t    cmd;
  ffba_pkg::dp_status_t dp_st;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (dp_st),
    .cmd       (cmd)
  );

  ffba_dp #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .LIVE_ENTRIES (LIVE_ENTRIES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .request_size   (request_size),
    .block_address  (block_address),
    .cmd            (cmd),
    .st             (dp_st),
    .result_address (result_address),
    .status         (status)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for first_fit_block_allocator: directed requests, then random phases.
// A scoreboard class predicts the free list, live table and heap top for every request.
// Depends on ffba_pkg and the allocator RTL only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR        = 16;
  localparam int SLOTS      = 64;
  localparam int CYCLE_CAP  = 2000000;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    bit [ffba_pkg::ADDR_W-1:0] addr;
    ffba_pkg::status_t         st;
  } grant_t;

  class alloc_scoreboard;
    bit [ffba_pkg::INIT_SIZE_W-1:0]  init_size = ffba_pkg::INIT_SIZE_RESET;
    bit [ffba_pkg::HEAP_LIMIT_W-1:0] limit     = ffba_pkg::HEAP_LIMIT_RESET;
    bit [19:0]  fr_start[SLOTS];
    bit [19:0]  fr_len[SLOTS];
    int         fr_cnt;
    bit [19:0]  lv_start[SLOTS];
    bit [19:0]  lv_len[SLOTS];
    bit         lv_used[SLOTS];
    bit [20:0]  top;
    bit         started;
    grant_t     awaited[$];
    int         errors;
    int         checked;
    int         seen[4];

    function int live_index(bit [19:0] addr);
      for (int i = 0; i < SLOTS; i++)
        if (lv_used[i] && longint'(lv_start[i]) + HDR == longint'(addr)) return i;
      return -1;
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (lv_used[i]) n += lv_used[i];
      return n;
    endfunction

    // user address of a random live block, 0 when none is live
    function bit [19:0] any_live();
      int idx[$];
      foreach (lv_used[i]) if (lv_used[i]) idx.push_back(i);
      if (idx.size() == 0) return 0;
      return 20'(lv_start[idx[$urandom_range(0, idx.size() - 1)]] + HDR);
    endfunction

    function void grant(longint size, output bit [19:0] addr,
                        output ffba_pkg::status_t st);
      int slot;
      int hit;
      longint start, len, lim;
      addr = 0;
      if (!started) begin
        started = 1;
        top = 21'(init_size);
        fr_start[0] = 0;
        fr_len[0] = (init_size > HDR) ? 20'(init_size - HDR) : 20'd0;
        fr_cnt = 1;
      end
      slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!lv_used[i]) slot = i;
      if (slot < 0) begin
        st = ffba_pkg::ST_FULL;
        return;
      end
      hit = -1;
      for (int i = fr_cnt - 1; i >= 0; i--) if (fr_len[i] >= size) hit = i;
      if (hit >= 0) begin
        start = fr_start[hit];
        len = fr_len[hit];
        if (len > size + HDR) begin
          fr_start[hit] = 20'(start + HDR + size);
          fr_len[hit] = 20'(len - size - HDR);
          len = size;
        end else begin
          for (int i = hit; i < fr_cnt - 1; i++) begin
            fr_start[i] = fr_start[i+1];
            fr_len[i] = fr_len[i+1];
          end
          fr_cnt--;
        end
      end else begin
        lim = (limit < 21'hFFFFF) ? limit : 21'hFFFFF;
        if (longint'(top) + size + HDR > lim) begin
          st = ffba_pkg::ST_OOM;
          return;
        end
        start = top;
        len = size;
        top = 21'(top + size + HDR);
      end
      lv_used[slot] = 1;
      lv_start[slot] = 20'(start);
      lv_len[slot] = 20'(len);
      st = ffba_pkg::ST_OK;
      addr = 20'(start + HDR);
    endfunction

    function void note_request(ffba_pkg::opcode_t op, bit [19:0] size, bit [19:0] addr);
      grant_t g;
      int k;
      g.addr = 0;
      g.st = ffba_pkg::ST_OK;
      case (op)
        ffba_pkg::OP_ALLOC: grant(size, g.addr, g.st);
        ffba_pkg::OP_FREE: if (addr != 0) begin
          k = live_index(addr);
          if (k < 0) g.st = ffba_pkg::ST_NOT_FOUND;
          else if (fr_cnt >= SLOTS) g.st = ffba_pkg::ST_FULL;
          else begin
            for (int i = fr_cnt; i > 0; i--) begin
              fr_start[i] = fr_start[i-1];
              fr_len[i] = fr_len[i-1];
            end
            fr_start[0] = lv_start[k];
            fr_len[0] = lv_len[k];
            fr_cnt++;
            lv_used[k] = 0;
          end
        end
        ffba_pkg::OP_RESIZE: if (addr == 0) grant(size, g.addr, g.st);
        else begin
          k = live_index(addr);
          if (k < 0) g.st = ffba_pkg::ST_NOT_FOUND;
          else if (size > lv_len[k]) grant(size, g.addr, g.st);
          else g.addr = addr;
        end
        default: ;
      endcase
      awaited.push_back(g);
    endfunction

    function void check_result(bit [19:0] addr, ffba_pkg::status_t st);
      grant_t g;
      checked++;
      seen[st]++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: addr %0d status %s", addr, st.name());
        return;
      end
      g = awaited.pop_front();
      if (g.addr !== addr || g.st !== st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %0d: expected addr %0d %s, got addr %0d %s",
                   checked, g.addr, g.st.name(), addr, st.name());
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [ffba_pkg::OP_W-1:0]   opcode = '0;
  logic [ffba_pkg::REQ_W-1:0]  request_size = '0;
  logic [ffba_pkg::ADDR_W-1:0] block_address = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [ffba_pkg::ADDR_W-1:0] result_address;
  logic [ffba_pkg::ST_W-1:0]   status;
  logic cfg_write = 0;
  logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  alloc_scoreboard sb = new();
  int cycles;
  int accepted;
  int burst_left;
  bit long_hold;
  int stall_mode;

  first_fit_block_allocator u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(result_address, ffba_pkg::status_t'(status));

  // receiver stall pattern: redraw the random stall mode periodically
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= long_hold;
      1: out_stall <= long_hold || ($urandom_range(0, 3) == 0);
      2: out_stall <= long_hold || ($urandom_range(0, 1) == 0);
      default: out_stall <= long_hold || ($urandom_range(0, 7) != 0);
    endcase
  end

  // hold the output off for a long stretch while requests keep coming
  initial begin
    long_hold = 0;
    wait (accepted > 400);
    @(posedge clk);
    long_hold <= 1;
    repeat (2500) @(posedge clk);
    long_hold <= 0;
  end

  // one write, then wait with cfg_write low so back-to-back writes never collide
  task automatic write_reg(logic [ffba_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val[ffba_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 0;
    if (idx == ffba_pkg::CFG_INITIAL_SIZE) sb.init_size = val[ffba_pkg::INIT_SIZE_W-1:0];
    else sb.limit = val[ffba_pkg::HEAP_LIMIT_W-1:0];
    @(posedge clk);
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic transfer(ffba_pkg::opcode_t op, bit [19:0] size, bit [19:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1;
    opcode <= op;
    request_size <= size;
    block_address <= addr;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, size, addr);
    accepted++;
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic bit [19:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 20'($urandom_range(0, 200));
    if (r < 96) return 20'($urandom_range(0, 4000));
    return 20'($urandom);
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) transfer(ffba_pkg::OP_ALLOC, pick_size(), 0);
    else if (r < 65) transfer(ffba_pkg::OP_FREE, 0, sb.any_live());
    else if (r < 80) transfer(ffba_pkg::OP_RESIZE, pick_size(), sb.any_live());
    else if (r < 85) transfer(ffba_pkg::OP_FREE, 20'($urandom), 20'($urandom));
    else if (r < 90)
      transfer(ffba_pkg::OP_RESIZE, pick_size(),
               ($urandom_range(0, 1)) ? 20'd0 : 20'($urandom));
    else if (r < 95) transfer(ffba_pkg::OP_FREE, 20'($urandom), 0);
    else transfer(ffba_pkg::OP_NONE, 20'($urandom), 20'($urandom));
  endtask

  initial begin
    int unsigned lims[5];
    bit [19:0] a;
    lims = '{21'd1048576, 21'd0, 21'd20000, 21'h1FFFFF, 21'd300000};
    repeat (6) @(posedge clk);
    rst <= 0;
    // only the first allocate reads the initial size
    case ($urandom_range(0, 3))
      0: write_reg(ffba_pkg::CFG_INITIAL_SIZE, 8);
      1: write_reg(ffba_pkg::CFG_INITIAL_SIZE, 32);
      2: write_reg(ffba_pkg::CFG_INITIAL_SIZE, 65536);
      default: write_reg(ffba_pkg::CFG_INITIAL_SIZE, $urandom_range(32, 65536));
    endcase
    write_reg(ffba_pkg::CFG_HEAP_LIMIT, 1048576);

    transfer(ffba_pkg::OP_FREE, 0, 0);
    transfer(ffba_pkg::OP_FREE, 0, 20'hFFFFF);
    transfer(ffba_pkg::OP_RESIZE, 0, 20'hFFFFF);
    transfer(ffba_pkg::OP_NONE, 20'hFFFFF, 20'hFFFFF);
    transfer(ffba_pkg::OP_ALLOC, 0, 0);
    transfer(ffba_pkg::OP_ALLOC, 1, 0);
    transfer(ffba_pkg::OP_ALLOC, 20'hFFFFF, 0);
    transfer(ffba_pkg::OP_RESIZE, 100, 0);
    transfer(ffba_pkg::OP_ALLOC, 64, 0);
    a = sb.any_live();
    transfer(ffba_pkg::OP_RESIZE, 0, a);
    transfer(ffba_pkg::OP_RESIZE, 5000, a);
    transfer(ffba_pkg::OP_FREE, 0, a);
    transfer(ffba_pkg::OP_FREE, 0, a);
    transfer(ffba_pkg::OP_RESIZE, 8, a);
    transfer(ffba_pkg::OP_ALLOC, 64, 0);
    transfer(ffba_pkg::OP_ALLOC, 900000, 0);
    transfer(ffba_pkg::OP_FREE, 0, sb.any_live());
    transfer(ffba_pkg::OP_ALLOC, 0, 0);
    transfer(ffba_pkg::OP_ALLOC, 20'hFFFFF, 0);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ffba_pkg::CFG_HEAP_LIMIT, lims[ph]);
      write_reg(ffba_pkg::CFG_INITIAL_SIZE, $urandom_range(0, 131071));
      if (ph == 2) begin
        // fill the live table, then free everything to overflow the free list
        for (int r = 0; r < 3; r++) begin
          repeat (70) transfer(ffba_pkg::OP_ALLOC, 20'($urandom_range(0, 40)), 0);
          for (int n = 0; n < 80 && sb.live_count() > 0; n++)
            transfer(ffba_pkg::OP_FREE, 0, sb.any_live());
          transfer(ffba_pkg::OP_FREE, 0, 20'(sb.lv_start[0] + HDR));
        end
      end else begin
        repeat (250) random_request();
      end
      settle();
    end

    $display("%0d requests: %0d ok, %0d out of memory, %0d not found, %0d table full",
             accepted, sb.seen[ffba_pkg::ST_OK], sb.seen[ffba_pkg::ST_OOM],
             sb.seen[ffba_pkg::ST_NOT_FOUND], sb.seen[ffba_pkg::ST_FULL]);
    $display("covered directed corners, five heap limits and live/free table overflow");
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire

// File: first_fit_block_allocator.f
sv/ffba_pkg.sv
sv/ffba_dp.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator.sv
bench/tb.sv
